[src/rc4_pkg.sv]
// ---------------------------------------------------------------------------
// RC4 stream cipher package
// Shared widths, types and codes for the RC4 cipher engine.
// ---------------------------------------------------------------------------
package rc4_pkg;

   // byte datapath and permutation table size
   localparam int BYTE_W      = 8;
   localparam int TABLE_DEPTH = 256;

   // key length register width, default key store size and reset value
   localparam int LEN_W          = 9;
   localparam int KEY_BYTES_DEF  = 256;
   localparam int KEY_LEN_RESET  = 256;

   // packed stream widths
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 8;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [LEN_W-1:0]  len_type;

   // item kind carried in tuser
   localparam logic FUNC_KEY  = 1'b0;
   localparam logic FUNC_DATA = 1'b1;

endpackage

[src/rc4_stream_cipher_unit.sv]
// ---------------------------------------------------------------------------
// RC4 stream cipher unit
// Key store, key schedule and keystream generation around one permutation
// memory with registered read data.
// ---------------------------------------------------------------------------
// A key-load transfer (tuser = 0) writes one key byte. A data transfer
// (tuser = 1) issues the read of S[i] at acceptance, then steps through
// the read of S[j], the write of S[j], the write of S[i] with the read of
// S[S[i]+S[j]], and the output load. The next request is taken only after
// the return to idle. The first data byte of a message (after reset or
// after a byte with tlast set) first rebuilds the table: an identity fill,
// then 256 schedule steps, with a lead-in read of the table before the
// schedule and before the byte. All of this is paced by the single read
// and single write port of the 256 x 8 permutation memory. The result
// register lets the next transfer be taken while a result waits; a finished
// byte waits for that register to free. key_length is written on the csr
// channel, which is always ready; a value of zero or above KEY_BYTES means
// KEY_BYTES.
module rc4_stream_cipher_unit #(
   parameter int KEY_BYTES = rc4_pkg::KEY_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] key_index, [15:8] key_byte, [23:16] data_byte
   input  logic [rc4_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [0] func
   input  logic                            req_tuser,
   input  logic                            req_tlast,
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] out_byte
   output logic [rc4_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,
   // key length register write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rc4_pkg::LEN_W-1:0]       csr_wdata
);

   localparam int KW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
   typedef logic [KW-1:0] kidx_type;

   // sequencer codes
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_INIT     = 4'd1;
   localparam logic [3:0] ST_KS_START = 4'd2;
   localparam logic [3:0] ST_KS_RD_J  = 4'd3;
   localparam logic [3:0] ST_KS_WR_J  = 4'd4;
   localparam logic [3:0] ST_KS_WR_I  = 4'd5;
   localparam logic [3:0] ST_D_RD_I   = 4'd6;
   localparam logic [3:0] ST_D_RD_J   = 4'd7;
   localparam logic [3:0] ST_D_WR_J   = 4'd8;
   localparam logic [3:0] ST_D_WR_I   = 4'd9;
   localparam logic [3:0] ST_D_OUT    = 4'd10;

   // control registers
   logic [3:0]        state_ff, state_in;
   rc4_pkg::byte_type i_ff, i_in;
   rc4_pkg::byte_type j_ff, j_in;
   logic              keyed_ff, keyed_in;
   kidx_type          kpos_ff, kpos_in;
   rc4_pkg::len_type  key_len_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload registers
   rc4_pkg::byte_type si_ff, si_in;
   rc4_pkg::byte_type sj_ff, sj_in;
   logic              fwd_ff, fwd_in;
   rc4_pkg::byte_type data_ff, data_in;
   logic              last_ff, last_in;
   rc4_pkg::byte_type rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   // memories
   rc4_pkg::byte_type perm_mem_ff [rc4_pkg::TABLE_DEPTH];
   rc4_pkg::byte_type key_mem_ff  [KEY_BYTES];
   rc4_pkg::byte_type perm_rdata_ff;
   rc4_pkg::byte_type key_rdata_ff;

   // memory port controls
   logic              perm_we;
   rc4_pkg::byte_type perm_waddr;
   rc4_pkg::byte_type perm_wdata;
   rc4_pkg::byte_type perm_raddr;
   logic              key_we;

   // request fields
   rc4_pkg::byte_type req_key_index;
   rc4_pkg::byte_type req_key_byte;
   rc4_pkg::byte_type req_data_byte;

   // helpers
   rc4_pkg::len_type  len_eff;
   rc4_pkg::byte_type ks_sum;
   rc4_pkg::byte_type swap_sum;
   rc4_pkg::byte_type i_next;
   kidx_type          kpos_step;
   logic              out_free;
   logic              key_in_range;

   assign req_key_index = req_tdata[7:0];
   assign req_key_byte  = req_tdata[15:8];
   assign req_data_byte = req_tdata[23:16];

   // ports
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;

   // effective key length, zero or oversize means full store
   always_comb begin
      if ((key_len_ff == '0) || (key_len_ff > rc4_pkg::len_type'(KEY_BYTES))) begin
         len_eff = rc4_pkg::len_type'(KEY_BYTES);
      end else begin
         len_eff = key_len_ff;
      end
   end

   // key position wraps at the key length
   assign kpos_step = ((rc4_pkg::len_type'(kpos_ff) + 1'b1) == len_eff) ?
                      '0 : kidx_type'(kpos_ff + 1'b1);

   assign ks_sum       = rc4_pkg::byte_type'(j_ff + perm_rdata_ff + key_rdata_ff);
   assign swap_sum     = rc4_pkg::byte_type'(si_ff + sj_ff);
   assign i_next       = rc4_pkg::byte_type'(i_ff + 1'b1);
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign key_in_range = (rc4_pkg::len_type'(req_key_index) <
                          rc4_pkg::len_type'(KEY_BYTES));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      keyed_in     = keyed_ff;
      kpos_in      = kpos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      si_in        = si_ff;
      sj_in        = sj_ff;
      fwd_in       = fwd_ff;
      data_in      = data_ff;
      last_in      = last_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      perm_we      = 1'b0;
      perm_waddr   = i_ff;
      perm_wdata   = sj_ff;
      perm_raddr   = i_ff;
      key_we       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == rc4_pkg::FUNC_KEY) begin
                  key_we = key_in_range;
               end else begin
                  data_in = req_data_byte;
                  last_in = req_tlast;
                  if (keyed_ff) begin
                     i_in       = i_next;
                     perm_raddr = i_next;
                     state_in   = ST_D_RD_J;
                  end else begin
                     i_in     = '0;
                     state_in = ST_INIT;
                  end
               end
            end
         end
         // identity fill
         ST_INIT: begin
            perm_we    = 1'b1;
            perm_waddr = i_ff;
            perm_wdata = i_ff;
            i_in       = i_next;
            if (i_ff == '1) begin
               j_in     = '0;
               kpos_in  = '0;
               state_in = ST_KS_START;
            end
         end
         ST_KS_START: begin
            perm_raddr = i_ff;
            state_in   = ST_KS_RD_J;
         end
         // schedule step: j += S[n] + K[n mod len]
         ST_KS_RD_J: begin
            si_in      = perm_rdata_ff;
            j_in       = ks_sum;
            perm_raddr = ks_sum;
            state_in   = ST_KS_WR_J;
         end
         ST_KS_WR_J: begin
            sj_in      = perm_rdata_ff;
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = si_ff;
            state_in   = ST_KS_WR_I;
         end
         // finish the swap and fetch the next S[n]
         ST_KS_WR_I: begin
            perm_we    = 1'b1;
            perm_waddr = i_ff;
            perm_wdata = sj_ff;
            i_in       = i_next;
            perm_raddr = i_next;
            kpos_in    = kpos_step;
            if (i_ff == '1) begin
               j_in     = '0;
               keyed_in = 1'b1;
               state_in = ST_D_RD_I;
            end else begin
               state_in = ST_KS_RD_J;
            end
         end
         ST_D_RD_I: begin
            i_in       = i_next;
            perm_raddr = i_next;
            state_in   = ST_D_RD_J;
         end
         // j += S[i]
         ST_D_RD_J: begin
            si_in      = perm_rdata_ff;
            j_in       = rc4_pkg::byte_type'(j_ff + perm_rdata_ff);
            perm_raddr = rc4_pkg::byte_type'(j_ff + perm_rdata_ff);
            state_in   = ST_D_WR_J;
         end
         ST_D_WR_J: begin
            sj_in      = perm_rdata_ff;
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = si_ff;
            state_in   = ST_D_WR_I;
         end
         // write S[i] and read the keystream entry; same entry is forwarded
         ST_D_WR_I: begin
            perm_we    = 1'b1;
            perm_waddr = i_ff;
            perm_wdata = sj_ff;
            perm_raddr = swap_sum;
            fwd_in     = (swap_sum == i_ff);
            state_in   = ST_D_OUT;
         end
         ST_D_OUT: begin
            perm_raddr = swap_sum;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = data_ff ^ (fwd_ff ? sj_ff : perm_rdata_ff);
               rsp_last_in  = last_ff;
               if (last_ff) begin
                  keyed_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         keyed_ff     <= 1'b0;
         kpos_ff      <= '0;
         key_len_ff   <= rc4_pkg::len_type'(rc4_pkg::KEY_LEN_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         keyed_ff     <= keyed_in;
         kpos_ff      <= kpos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            key_len_ff <= csr_wdata;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      fwd_ff      <= fwd_in;
      data_ff     <= data_in;
      last_ff     <= last_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   // permutation memory
   always_ff @(posedge clock) begin
      if (perm_we) begin
         perm_mem_ff[perm_waddr] <= perm_wdata;
      end
      perm_rdata_ff <= perm_mem_ff[perm_raddr];
   end

   // key memory, read address follows the next key position
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem_ff[kidx_type'(req_key_index)] <= req_key_byte;
      end
      key_rdata_ff <= key_mem_ff[kpos_in];
   end

   // an unkeyed data transfer starts the identity fill
   a_rekey_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == rc4_pkg::FUNC_DATA) && !keyed_ff)
      |=> (state_ff == ST_INIT))
      else $error("unkeyed data transfer did not start key schedule");

   // schedule end leaves i and j at zero and the table keyed
   a_sched_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_KS_WR_I) && (i_ff == '1))
      |=> (keyed_ff && (i_ff == '0) && (j_ff == '0) && (state_ff == ST_D_RD_I)))
      else $error("key schedule did not end with cleared indexes");

   // a result only appears from the output step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_D_OUT))
      else $error("response raised outside output step");

   // a last byte clears the key state when its result is loaded
   a_last_rekeys: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_D_OUT) && out_free && last_ff) |=> !keyed_ff)
      else $error("last byte did not force a re-key");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// RC4 stream cipher unit testbench
// Loads the key store, then sends messages of data bytes through the cipher
// while the key length is changed between phases. A built-in predictor runs
// the key schedule and keystream on its own copy of the permutation table.
// Each response transfer is checked against the oldest expected byte.
// ---------------------------------------------------------------------------
module tb_top;

   localparam int PERIOD_NS     = 10;
   localparam int RESET_CYCLES  = 8;
   // no transfer for this long means the unit is hung
   localparam int STALL_LIMIT   = 20000;
   // cycles allowed for a key-load transfer to settle before a csr write
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 3000;
   localparam int PHASE_ITEMS   = 180;

   typedef struct packed {
      logic              func;
      rc4_pkg::byte_type key_index;
      rc4_pkg::byte_type key_byte;
      rc4_pkg::byte_type data_byte;
      logic              last;
   } cipher_req_type;

   typedef struct packed {
      rc4_pkg::byte_type out_byte;
      logic              out_last;
   } cipher_rsp_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [rc4_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                           req_tuser;
   logic                           req_tlast;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [rc4_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tlast;
   logic                           csr_valid;
   logic                           csr_ready;
   rc4_pkg::len_type               csr_wdata;

   // predictor state
   rc4_pkg::byte_type perm_s [rc4_pkg::TABLE_DEPTH];
   rc4_pkg::byte_type key_mem [rc4_pkg::KEY_BYTES_DEF];
   rc4_pkg::byte_type idx_i;
   rc4_pkg::byte_type idx_j;
   logic              table_keyed;
   rc4_pkg::len_type  key_len_reg;

   cipher_rsp_type expected_bytes [$];
   int             error_count;
   int             items_sent;
   bit             idle_on;
   int             rsp_hold_cycles;
   int             quiet_cycles = 0;

   rc4_stream_cipher_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   // clock
   initial clock = 1'b0;
   always #(PERIOD_NS / 2) clock = ~clock;

   // keystream predictor: re-keys on the first byte of a message
   function automatic cipher_rsp_type cipher_byte(rc4_pkg::byte_type data, logic last);
      cipher_rsp_type    res;
      int unsigned       len;
      rc4_pkg::byte_type ni;
      rc4_pkg::byte_type nj;
      rc4_pkg::byte_type tmp;
      rc4_pkg::byte_type sum;
      if (!table_keyed) begin
         len = (key_len_reg == 0 || key_len_reg > rc4_pkg::KEY_BYTES_DEF) ?
               rc4_pkg::KEY_BYTES_DEF : key_len_reg;
         for (int n = 0; n < rc4_pkg::TABLE_DEPTH; n++)
            perm_s[n] = rc4_pkg::byte_type'(n);
         nj = '0;
         for (int n = 0; n < rc4_pkg::TABLE_DEPTH; n++) begin
            nj = nj + perm_s[n] + key_mem[n % len];
            tmp = perm_s[n];
            perm_s[n] = perm_s[nj];
            perm_s[nj] = tmp;
         end
         idx_i = '0;
         idx_j = '0;
         table_keyed = 1'b1;
      end
      ni = idx_i + 8'd1;
      nj = idx_j + perm_s[ni];
      tmp = perm_s[ni];
      perm_s[ni] = perm_s[nj];
      perm_s[nj] = tmp;
      sum = perm_s[ni] + perm_s[nj];
      idx_i = ni;
      idx_j = nj;
      res.out_byte = data ^ perm_s[sum];
      res.out_last = last;
      if (last) table_keyed = 1'b0;
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   // send one request transfer; called and returns at a falling edge
   task automatic send_item(cipher_req_type item);
      while (idle_on && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {item.data_byte, item.key_byte, item.key_index};
      req_tuser  <= item.func;
      req_tlast  <= item.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (item.func == rc4_pkg::FUNC_KEY)
         key_mem[item.key_index] = item.key_byte;
      else
         expected_bytes.push_back(cipher_byte(item.data_byte, item.last));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_key(int idx, int value);
      cipher_req_type item;
      item.func      = rc4_pkg::FUNC_KEY;
      item.key_index = rc4_pkg::byte_type'(idx);
      item.key_byte  = rc4_pkg::byte_type'(value);
      item.data_byte = rc4_pkg::byte_type'($urandom_range(255));
      item.last      = 1'($urandom_range(1));
      send_item(item);
   endtask

   task automatic send_data(int value, logic last);
      cipher_req_type item;
      item.func      = rc4_pkg::FUNC_DATA;
      item.key_index = rc4_pkg::byte_type'($urandom_range(255));
      item.key_byte  = rc4_pkg::byte_type'($urandom_range(255));
      item.data_byte = rc4_pkg::byte_type'(value);
      item.last      = last;
      send_item(item);
   endtask

   // data bytes with random content, key writes mixed in at key_pct percent
   task automatic send_message(int n_bytes, int key_pct, bit with_last);
      for (int b = 0; b < n_bytes; b++) begin
         if ($urandom_range(99) < key_pct)
            send_key($urandom_range(255), $urandom_range(255));
         send_data($urandom_range(255), with_last && (b == n_bytes - 1));
      end
   endtask

   // wait until every expected byte has come back and key loads have settled
   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_key_length(int value);
      wait_for_idle();
      csr_valid <= 1'b1;
      csr_wdata <= rc4_pkg::len_type'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      key_len_reg = rc4_pkg::len_type'(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // fill the whole key store so no key schedule reads an unwritten entry
   task automatic test_key_fill();
      for (int k = 0; k < rc4_pkg::KEY_BYTES_DEF; k++)
         send_key(k, (k == 0) ? 8'h00 : (k == rc4_pkg::KEY_BYTES_DEF - 1) ? 8'hFF :
                  $urandom_range(255));
   endtask

   task automatic test_directed();
      // single-byte message at the reset key length
      send_data(8'h00, 1'b1);
      send_data(8'hFF, 1'b0);
      send_data(8'h5A, 1'b0);
      send_data(8'hA5, 1'b1);
      // shortest key
      write_key_length(1);
      send_data(8'h00, 1'b0);
      send_data(8'hFF, 1'b1);
      // zero length means full key store
      write_key_length(0);
      send_data(8'h3C, 1'b1);
      // length above the store saturates; key changes mid-message wait
      write_key_length(511);
      send_data(8'hFF, 1'b0);
      send_key(0, 8'hFF);
      send_key(255, 8'h00);
      send_data(8'h00, 1'b1);
      // length change mid-message does not disturb the running keystream
      write_key_length(2);
      send_data(8'h81, 1'b0);
      send_data(8'h7E, 1'b0);
      write_key_length(7);
      send_data(8'h01, 1'b0);
      send_data(8'h80, 1'b1);
      send_data(8'hC3, 1'b1);
      wait_for_idle();
   endtask

   // receiver stalls long enough for the unit to back up into its input
   task automatic test_backpressure();
      wait_for_idle();
      @(posedge clock);
      rsp_hold_cycles = HOLD_CYCLES;
      @(negedge clock);
      send_message(40, 0, 1'b1);
      wait_for_idle();
   endtask

   task automatic test_random_phase(int key_len, bit with_idle);
      int target;
      int r;
      write_key_length(key_len);
      idle_on = with_idle;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
         // occasional stray key writes between messages
         if ($urandom_range(99) < 10)
            repeat ($urandom_range(4, 1))
               send_key($urandom_range(255), $urandom_range(255));
         r = $urandom_range(99);
         if (r < 4)
            send_message($urandom_range(300, 257), 3, 1'b1);
         else if (r < 25)
            send_message(1, 8, 1'b1);
         else
            send_message($urandom_range(24, 2), 8, 1'b1);
      end
      wait_for_idle();
      idle_on = 1'b1;
   endtask

   // response checker
   always @(posedge clock) begin
      cipher_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch("unexpected transfer, data", rsp_tdata, 0);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata !== want.out_byte)
               report_mismatch("out_byte", rsp_tdata, want.out_byte);
            if (rsp_tlast !== want.out_last)
               report_mismatch("out_last", rsp_tlast, want.out_last);
         end
      end
   end

   // receiver: random stalls plus the long hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(idle_on && $urandom_range(99) < 6);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[%0t] timeout with %0d bytes outstanding", $time,
                  expected_bytes.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = rc4_pkg::FUNC_KEY;
      req_tlast       = 1'b0;
      csr_valid       = 1'b0;
      csr_wdata       = '0;
      error_count     = 0;
      items_sent      = 0;
      idle_on         = 1'b1;
      rsp_hold_cycles = 0;
      idx_i           = '0;
      idx_j           = '0;
      table_keyed     = 1'b0;
      key_len_reg     = rc4_pkg::len_type'(rc4_pkg::KEY_LEN_RESET);
      foreach (perm_s[n]) perm_s[n] = '0;
      foreach (key_mem[n]) key_mem[n] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_key_fill();
      test_directed();
      test_backpressure();
      test_random_phase($urandom_range(16, 1), 1'b1);
      test_random_phase(256, 1'b1);
      test_random_phase($urandom_range(511, 1), 1'b1);
      test_random_phase(1, 1'b1);
      // back-to-back stretch with no idling on either side
      test_random_phase($urandom_range(32, 1), 1'b0);
      test_random_phase($urandom_range(255, 2), 1'b1);

      wait_for_idle();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
